// File: hw/rtl/ucws_pkg.sv
// ----------------------------------------------------------------------------
// ucws_pkg: shared types and helpers for the UTF-8 / CJK word splitter
// Holds the group record passed from the classifier to the serializer,
// the queue sizing and the byte-class functions.
// ----------------------------------------------------------------------------
package ucws_pkg;

  localparam int unsigned GroupBytes = 4;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  localparam logic [7:0] LeadFourLo  = 8'hF0;
  localparam logic [7:0] LeadFourHi  = 8'hF7;
  localparam logic [7:0] LeadThreeLo = 8'hE0;
  localparam logic [7:0] LeadThreeHi = 8'hEF;
  localparam logic [7:0] LeadTwoLo   = 8'hC0;
  localparam logic [7:0] LeadTwoHi   = 8'hDF;
  localparam logic [7:0] CjkLeadLo   = 8'hE4;
  localparam logic [7:0] CjkLeadHi   = 8'hE9;
  localparam logic [7:0] ContLo      = 8'h80;
  localparam logic [7:0] ContHi      = 8'hBF;

  // One released character run: up to four bytes with their marks.
  typedef struct packed {
    logic [GroupBytes-1:0][7:0] bytes;
    logic [GroupBytes-1:0]      cs;        // character start
    logic [GroupBytes-1:0]      ws;        // word start
    logic [GroupBytes-1:0]      ch;        // Chinese character byte
    logic [1:0]                 last_idx;  // index of the final byte
    logic                       eot;       // run closes the text
  } ucws_group_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b >= LeadFourLo && b <= LeadFourHi) begin
      len = 3'd4;
    end else if (b >= LeadThreeLo && b <= LeadThreeHi) begin
      len = 3'd3;
    end else if (b >= LeadTwoLo && b <= LeadTwoHi) begin
      len = 3'd2;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b >= ContLo) && (b <= ContHi);
  endfunction

  function automatic logic is_cjk_lead(input logic [7:0] b);
    return (b >= CjkLeadLo) && (b <= CjkLeadHi);
  endfunction

endpackage

// File: hw/rtl/ucws_front.sv
// ----------------------------------------------------------------------------
// ucws_front: byte intake and character classifier
// Holds the bytes of an incomplete character, then parses the finished run
// and pushes it, fully marked, into the group queue.
// ----------------------------------------------------------------------------
module ucws_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,
  input  logic                 s_axis_tlast,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output ucws_pkg::ucws_group_t q_group_o
);
  import ucws_pkg::*;

  logic [2:0][7:0] held_q;
  logic [1:0]      held_cnt_q, held_cnt_d;
  logic [2:0]      char_len_q, char_len_d;
  logic            prev_chin_q, prev_chin_d;
  logic            at_start_q, at_start_d;

  logic       accept;
  logic [2:0] new_len;
  logic       complete;
  logic       emit;

  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign new_len       = lead_len(s_axis_tdata);
  assign complete      = (held_cnt_q == 2'd0) ? (new_len == 3'd1)
                                              : ({1'b0, held_cnt_q} + 3'd1 >= char_len_q);
  assign emit          = complete || s_axis_tlast;
  assign q_push_o      = accept && emit;

  // Parse the held bytes plus the new one; a character that runs past the
  // end shrinks to its lead byte.
  always_comb begin
    logic [5:0][7:0] bufx;
    logic [2:0]      n;
    logic [2:0]      p;
    logic [2:0]      len;
    logic            chin;
    logic            chin_cur;
    logic            prev;
    logic            atst;
    bufx     = '0;
    n        = {1'b0, held_cnt_q} + 3'd1;
    p        = 3'd0;
    len      = 3'd1;
    chin     = 1'b0;
    chin_cur = 1'b0;
    prev     = prev_chin_q;
    atst     = at_start_q;
    q_group_o = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < held_cnt_q) begin
        bufx[i] = held_q[i];
      end
    end
    bufx[{1'b0, held_cnt_q}] = s_axis_tdata;
    for (int i = 0; i < GroupBytes; i++) begin
      if (3'(i) < n) begin
        q_group_o.bytes[i] = bufx[i];
        if (3'(i) == p) begin
          len = lead_len(bufx[i]);
          if (len > n - 3'(i)) begin
            len = 3'd1;
          end
          chin = (len == 3'd3) && is_cjk_lead(bufx[i]) &&
                 is_cont(bufx[i+1]) && is_cont(bufx[i+2]);
          q_group_o.cs[i] = 1'b1;
          q_group_o.ws[i] = chin || atst || prev;
          chin_cur = chin;
          prev     = chin;
          atst     = 1'b0;
          p        = 3'(i) + len;
        end
        q_group_o.ch[i] = chin_cur;
      end
    end
    q_group_o.last_idx = held_cnt_q;
    q_group_o.eot      = s_axis_tlast;

    held_cnt_d  = held_cnt_q;
    char_len_d  = char_len_q;
    prev_chin_d = prev_chin_q;
    at_start_d  = at_start_q;
    if (accept) begin
      if (!emit) begin
        held_cnt_d = held_cnt_q + 2'd1;
        if (held_cnt_q == 2'd0) begin
          char_len_d = new_len;
        end
      end else begin
        held_cnt_d  = 2'd0;
        char_len_d  = 3'd0;
        prev_chin_d = s_axis_tlast ? 1'b0 : prev;
        at_start_d  = s_axis_tlast ? 1'b1 : atst;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q  <= 2'd0;
      char_len_q  <= 3'd0;
      prev_chin_q <= 1'b0;
      at_start_q  <= 1'b1;
    end else begin
      held_cnt_q  <= held_cnt_d;
      char_len_q  <= char_len_d;
      prev_chin_q <= prev_chin_d;
      at_start_q  <= at_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !emit) begin
      held_q[held_cnt_q] <= s_axis_tdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_held_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q != 2'd0 |-> ({1'b0, held_cnt_q} < char_len_q))
    else $error("held bytes reach the character length");
`endif

endmodule

// File: hw/rtl/ucws_queue.sv
// ----------------------------------------------------------------------------
// ucws_queue: group queue between classifier and serializer
// Small FIFO of marked character runs; lets each side stall on its own.
// ----------------------------------------------------------------------------
module ucws_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ucws_pkg::ucws_group_t group_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output ucws_pkg::ucws_group_t group_o,
  output logic                  empty_o
);
  import ucws_pkg::*;

  ucws_group_t              slots_q [QueueDepth];
  logic [QueueAw-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]         count_q;

  assign full_o  = count_q == (QueueAw+1)'(QueueDepth);
  assign empty_o = count_q == '0;
  assign group_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= group_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into a full group queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from an empty group queue");
`endif

endmodule

// File: hw/rtl/ucws_back.sv
// ----------------------------------------------------------------------------
// ucws_back: run serializer and output register
// Sends one marked run at a time, one byte per cycle while output is ready.
// ----------------------------------------------------------------------------
module ucws_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  ucws_pkg::ucws_group_t q_group_i,
  output logic                  q_pop_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,
  output logic [3:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);
  import ucws_pkg::*;

  ucws_group_t cur_q;
  logic        cur_valid_q;
  logic [1:0]  idx_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic [3:0]  out_user_q;
  logic        out_last_q;

  logic advance;
  logic send;
  logic cur_last;

  assign advance  = !out_valid_q || m_axis_tready;
  assign send     = advance && cur_valid_q;
  assign cur_last = idx_q == cur_q.last_idx;
  assign q_pop_o  = !q_empty_i && (!cur_valid_q || (send && cur_last));

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        cur_valid_q <= 1'b1;
        idx_q       <= 2'd0;
      end else if (send && cur_last) begin
        cur_valid_q <= 1'b0;
      end else if (send) begin
        idx_q <= idx_q + 2'd1;
      end
      if (send) begin
        out_valid_q <= 1'b1;
      end else if (advance) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_group_i;
    end
    if (send) begin
      out_byte_q <= cur_q.bytes[idx_q];
      out_user_q <= {cur_last, cur_q.ch[idx_q], cur_q.ws[idx_q], cur_q.cs[idx_q]};
      out_last_q <= cur_last && cur_q.eot;
    end
  end

`ifndef NO_ASSERTIONS
  a_ws_on_cs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_user_q[1] || out_user_q[0]))
    else $error("word start on a byte that is not a character start");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (idx_q <= cur_q.last_idx))
    else $error("serializer index past the end of the run");
`endif

endmodule

// File: hw/rtl/utf8_cjk_word_splitter.sv
// ----------------------------------------------------------------------------
// utf8_cjk_word_splitter: UTF-8 character and CJK word segmentation
// Splits a byte stream into characters and words and marks every byte.
//
//   channel  dir  tdata        tuser [0..3]                       tlast
//   s_axis   in   text_byte    -                                  text_end
//   m_axis   out  out_byte     char_start, word_start,            end_of_text
//                              is_chinese, last_of_run
//
// Takes one byte per cycle while the group queue has room and sends one byte
// per cycle while the output is ready. A character's bytes are held until the
// character is complete (or the text ends), then pass through the group queue,
// the current-run register and the output register. The four-run group queue
// sets how long input keeps flowing while the output stalls. Reset clears the
// held character and the word state; there is no clearing pass.
// ----------------------------------------------------------------------------
module utf8_cjk_word_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,   // text_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [3:0] m_axis_tuser,   // [0] char_start [1] word_start [2] is_chinese
                                     // [3] last_of_run
  output logic       m_axis_tlast    // end_of_text
);
  import ucws_pkg::*;

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  ucws_group_t q_in;
  ucws_group_t q_out;

  // Front: hold partial characters, classify finished runs.
  ucws_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_group_o     (q_in)
  );

  // Queue: decouple intake from byte-by-byte release.
  ucws_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .group_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .group_o (q_out),
    .empty_o (q_empty)
  );

  // Back: release runs via the output register, one byte per cycle unless stalled.
  ucws_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_group_i     (q_out),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
